[src/svpd_pkg.sv]
package svpd_pkg;

   localparam int VOLT_BITS = 16;
   localparam int ANGLE_BITS = 16;
   localparam int TURN_BITS = 24;
   localparam int CORDIC_STEPS = 23;
   localparam int DIV_STEPS = 15;
   localparam int RATIO_CLAMP = 18907;
   localparam int ONE_Q30 = 1 << 30;
   localparam int CORDIC_X0 = 652032874;
   localparam logic signed [31:0] SIN60_Q30 = 32'sd929887698;
   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775396;

   // floor(r / 6) = (r * SIXTH_RECIP) >> SIXTH_SHIFT for any 24-bit r.
   localparam int SIXTH_SHIFT = 27;
   localparam logic [24:0] SIXTH_RECIP = 25'd22369622;

   localparam logic [TURN_BITS-1:0] HALF_TURN = 24'h800000;
   localparam logic [TURN_BITS-1:0] QUARTER_TURN = 24'h400000;

   localparam int SUPPLY_BITS = 15;
   localparam int PERIOD_BITS = 16;
   localparam int COMPARE_BITS = 16;
   localparam int SECTOR_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUPPLY_VOLTAGE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PWM_PERIOD = 2'd1;

   localparam logic [SUPPLY_BITS-1:0] SUPPLY_RESET = 15'd3072;
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd1440;

   typedef struct packed {
      logic signed [VOLT_BITS-1:0] quad_voltage;
      logic signed [VOLT_BITS-1:0] direct_voltage;
      logic [ANGLE_BITS-1:0] rotor_angle;
   } req_payload_type;

   typedef struct packed {
      logic [COMPARE_BITS-1:0] compare_a;
      logic [COMPARE_BITS-1:0] compare_b;
      logic [COMPARE_BITS-1:0] compare_c;
      logic [SECTOR_BITS-1:0] sector_number;
   } rsp_payload_type;

   // Arctangent of 2^-step as a fraction of a turn, 24-bit scale.
   function automatic logic [TURN_BITS-1:0] atan_turn(input int step);
      logic [TURN_BITS-1:0] v;
      case (step)
         0: v = 24'd2097152;
         1: v = 24'd1238021;
         2: v = 24'd654136;
         3: v = 24'd332050;
         4: v = 24'd166669;
         5: v = 24'd83416;
         6: v = 24'd41718;
         7: v = 24'd20860;
         8: v = 24'd10430;
         9: v = 24'd5215;
         10: v = 24'd2608;
         11: v = 24'd1304;
         12: v = 24'd652;
         13: v = 24'd326;
         14: v = 24'd163;
         15: v = 24'd81;
         16: v = 24'd41;
         17: v = 24'd20;
         18: v = 24'd10;
         19: v = 24'd5;
         20: v = 24'd3;
         21: v = 24'd1;
         22: v = 24'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[src/space_vector_pwm_duty_unit.sv]
// Space vector PWM duty unit: turns a (q, d, angle) voltage command into three
// timer compare counts and the sector number.
// The req channel takes one command beat, the rsp channel gives one result beat
// per command, in order. The csr channel writes the supply voltage (index 0) and
// the PWM period (index 1) and is always ready; the user must write it only while
// no command is in flight (not enforced by the block). Other indexes are ignored.
// An accepted req beat passes a 23-cell atan2 CORDIC chain, one square-root cell
// per magnitude bit, a 15-cell ratio divider chain, a 23-cell sin/cos CORDIC chain
// and the multiplier stages that form the duties on its way to rsp valid. Every
// cell is one register stage, so a new command enters every cycle while the result
// beat is not stalled.
// The whole pipeline advances together; when rsp is valid and not taken, it
// holds and req_ready drops until the result beat is accepted, while the
// output register keeps the finished result.
// Reset empties the pipeline and loads supply 3072 and period 1440.
module space_vector_pwm_duty_unit
   import svpd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int V = VOLT_BITS;
   localparam int VW = VOLT_BITS + 22;
   localparam int SQW = 2 * VOLT_BITS;
   localparam int CMP_W = VOLT_BITS + SUPPLY_BITS;
   localparam int REQ_W = $bits(req_payload_type);
   localparam int ROOT_TAG_W = TURN_BITS + VOLT_BITS + 1;
   localparam int DIV_TAG_W = TURN_BITS + 2;
   localparam int U_W = DIV_STEPS + 1;
   localparam int ROT_TAG_W = U_W + SECTOR_BITS;
   localparam int SIX_W = TURN_BITS + 3;
   localparam int PHI_W = TURN_BITS - 2;
   localparam int RECIP_W = TURN_BITS + 25;
   localparam int RW = 33;
   localparam int RZW = 26;
   localparam int PW = 64;
   localparam int MW = RW + U_W;
   localparam int KW = 64;
   localparam int TW = 34;
   localparam int DUTY_W = 31;
   localparam int CPW = DUTY_W + PERIOD_BITS;

   logic adv;

   // ---------------- configuration ----------------
   logic [SUPPLY_BITS-1:0] supply_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [SUPPLY_BITS-1:0] supply_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SUPPLY_VOLTAGE: supply_ff <= csr_data[SUPPLY_BITS-1:0];
            CSR_PWM_PERIOD: period_ff <= csr_data[PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   // A zero supply divides as one, which saturates the ratio for any nonzero numerator.
   assign supply_eff = (supply_ff == '0) ? SUPPLY_BITS'(1) : supply_ff;

   // ---------------- input register ----------------
   logic v0_ff;
   req_payload_type req0_ff;

   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req0_ff <= req_payload;
      end
   end

   // ---------------- atan2 chain ----------------
   logic signed [VW-1:0] d_scaled;
   logic signed [VW-1:0] q_scaled;
   logic d_neg;

   logic vec_valid [CORDIC_STEPS+1];
   logic signed [VW-1:0] vec_x [CORDIC_STEPS+1];
   logic signed [VW-1:0] vec_y [CORDIC_STEPS+1];
   logic [TURN_BITS-1:0] vec_z [CORDIC_STEPS+1];
   logic [REQ_W-1:0] vec_tag [CORDIC_STEPS+1];

   assign d_scaled = VW'(req0_ff.direct_voltage) <<< 20;
   assign q_scaled = VW'(req0_ff.quad_voltage) <<< 20;
   assign d_neg = req0_ff.direct_voltage[V-1];

   // A negative d starts from the vector turned by half a turn.
   assign vec_valid[0] = v0_ff;
   assign vec_x[0] = d_neg ? -d_scaled : d_scaled;
   assign vec_y[0] = d_neg ? -q_scaled : q_scaled;
   assign vec_z[0] = d_neg ? HALF_TURN : '0;
   assign vec_tag[0] = req0_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      svpd_cordic_cell #(
         .XW(VW), .ZW(TURN_BITS), .STEP(k), .TAG_W(REQ_W), .VECTORING(1'b1)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(vec_valid[k]), .in_x(vec_x[k]), .in_y(vec_y[k]),
         .in_z(vec_z[k]), .in_tag(vec_tag[k]),
         .out_valid(vec_valid[k+1]), .out_x(vec_x[k+1]), .out_y(vec_y[k+1]),
         .out_z(vec_z[k+1]), .out_tag(vec_tag[k+1])
      );
   end

   // ---------------- angle sum and squares ----------------
   req_payload_type vec_req;
   logic [TURN_BITS-1:0] angle_turn;
   logic vec_d_zero;
   logic signed [SQW-1:0] dd_prod;
   logic signed [SQW-1:0] qq_prod;

   logic v1_ff;
   logic [TURN_BITS-1:0] theta1_ff, theta1_in;
   logic [SQW-1:0] dd1_ff;
   logic [SQW-1:0] qq1_ff;
   logic [V-1:0] q1_ff;
   logic dz1_ff;

   assign vec_req = vec_tag[CORDIC_STEPS];
   assign angle_turn = TURN_BITS'(vec_req.rotor_angle) << (TURN_BITS - ANGLE_BITS);
   assign vec_d_zero = (vec_req.direct_voltage == '0);
   assign theta1_in = angle_turn + (vec_d_zero ? QUARTER_TURN : vec_z[CORDIC_STEPS]);
   assign dd_prod = SQW'(vec_req.direct_voltage) * SQW'(vec_req.direct_voltage);
   assign qq_prod = SQW'(vec_req.quad_voltage) * SQW'(vec_req.quad_voltage);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= vec_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         theta1_ff <= theta1_in;
         dd1_ff <= dd_prod;
         qq1_ff <= qq_prod;
         q1_ff <= vec_req.quad_voltage;
         dz1_ff <= vec_d_zero;
      end
   end

   // ---------------- square root chain ----------------
   logic root_valid [V+1];
   logic [SQW-1:0] root_rem [V+1];
   logic [SQW-1:0] root_val [V+1];
   logic [ROOT_TAG_W-1:0] root_tag [V+1];

   assign root_valid[0] = v1_ff;
   assign root_rem[0] = dd1_ff + qq1_ff;
   assign root_val[0] = '0;
   assign root_tag[0] = {theta1_ff, q1_ff, dz1_ff};

   for (genvar k = 0; k < V; k++) begin : g_root
      svpd_root_cell #(
         .W(SQW), .STEP(k), .STEPS(V), .TAG_W(ROOT_TAG_W)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(root_valid[k]), .in_rem(root_rem[k]), .in_root(root_val[k]),
         .in_tag(root_tag[k]),
         .out_valid(root_valid[k+1]), .out_rem(root_rem[k+1]),
         .out_root(root_val[k+1]), .out_tag(root_tag[k+1])
      );
   end

   // ---------------- divider set-up ----------------
   logic [TURN_BITS-1:0] root_theta;
   logic [V-1:0] root_q;
   logic root_dz;
   logic [V-1:0] q_abs;
   logic [V-1:0] numer;

   logic v2_ff;
   logic [DIV_STEPS-1:0] rem2_ff;
   logic sat2_ff;
   logic neg2_ff;
   logic [TURN_BITS-1:0] theta2_ff;

   assign {root_theta, root_q, root_dz} = root_tag[V];
   assign q_abs = root_q[V-1] ? V'(~root_q + 1'b1) : root_q;
   assign numer = root_dz ? q_abs : root_val[V][V-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= root_valid[V];
      end
   end

   // A numerator at or above the supply gives a ratio of one or more, which
   // the clamp cuts anyway; below it the quotient needs only DIV_STEPS bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem2_ff <= DIV_STEPS'(numer);
         sat2_ff <= CMP_W'(numer) >= CMP_W'(supply_eff);
         neg2_ff <= root_dz && root_q[V-1];
         theta2_ff <= root_theta;
      end
   end

   // ---------------- divider chain ----------------
   logic div_valid [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] div_rem [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] div_quo [DIV_STEPS+1];
   logic [DIV_TAG_W-1:0] div_tag [DIV_STEPS+1];

   assign div_valid[0] = v2_ff;
   assign div_rem[0] = rem2_ff;
   assign div_quo[0] = '0;
   assign div_tag[0] = {theta2_ff, sat2_ff, neg2_ff};

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      svpd_div_cell #(
         .DW(DIV_STEPS), .TAG_W(DIV_TAG_W)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv), .divisor(supply_eff),
         .in_valid(div_valid[k]), .in_rem(div_rem[k]), .in_quo(div_quo[k]),
         .in_tag(div_tag[k]),
         .out_valid(div_valid[k+1]), .out_rem(div_rem[k+1]),
         .out_quo(div_quo[k+1]), .out_tag(div_tag[k+1])
      );
   end

   // ---------------- ratio clamp and sector ----------------
   logic [TURN_BITS-1:0] div_theta;
   logic div_sat;
   logic div_neg;
   logic [DIV_STEPS-1:0] ratio_mag;
   logic [SIX_W-1:0] theta6;

   logic v3_ff;
   logic signed [U_W-1:0] u3_ff;
   logic [SECTOR_BITS-1:0] sector3_ff;
   logic [TURN_BITS-1:0] r3_ff;

   assign {div_theta, div_sat, div_neg} = div_tag[DIV_STEPS];
   assign ratio_mag = (div_sat || div_quo[DIV_STEPS] > DIV_STEPS'(RATIO_CLAMP))
      ? DIV_STEPS'(RATIO_CLAMP) : div_quo[DIV_STEPS];
   assign theta6 = (SIX_W'(div_theta) << 2) + (SIX_W'(div_theta) << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= div_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u3_ff <= div_neg ? -$signed({1'b0, ratio_mag}) : $signed({1'b0, ratio_mag});
         sector3_ff <= theta6[SIX_W-1:TURN_BITS];
         r3_ff <= theta6[TURN_BITS-1:0];
      end
   end

   // ---------------- in-sector angle ----------------
   logic [RECIP_W-1:0] phi_prod;

   logic v4_ff;
   logic [PHI_W-1:0] phi4_ff;
   logic signed [U_W-1:0] u4_ff;
   logic [SECTOR_BITS-1:0] sector4_ff;

   assign phi_prod = RECIP_W'(r3_ff) * RECIP_W'(SIXTH_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phi4_ff <= phi_prod[SIXTH_SHIFT+PHI_W-1:SIXTH_SHIFT];
         u4_ff <= u3_ff;
         sector4_ff <= sector3_ff;
      end
   end

   // ---------------- sin/cos chain ----------------
   logic rot_valid [CORDIC_STEPS+1];
   logic signed [RW-1:0] rot_x [CORDIC_STEPS+1];
   logic signed [RW-1:0] rot_y [CORDIC_STEPS+1];
   logic [RZW-1:0] rot_z [CORDIC_STEPS+1];
   logic [ROT_TAG_W-1:0] rot_tag [CORDIC_STEPS+1];

   assign rot_valid[0] = v4_ff;
   assign rot_x[0] = RW'(CORDIC_X0);
   assign rot_y[0] = '0;
   assign rot_z[0] = RZW'(phi4_ff);
   assign rot_tag[0] = {u4_ff, sector4_ff};

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      svpd_cordic_cell #(
         .XW(RW), .ZW(RZW), .STEP(k), .TAG_W(ROT_TAG_W), .VECTORING(1'b0)
      ) u_cell (
         .clock(clock), .reset(reset), .enable(adv),
         .in_valid(rot_valid[k]), .in_x(rot_x[k]), .in_y(rot_y[k]),
         .in_z(rot_z[k]), .in_tag(rot_tag[k]),
         .out_valid(rot_valid[k+1]), .out_x(rot_x[k+1]), .out_y(rot_y[k+1]),
         .out_z(rot_z[k+1]), .out_tag(rot_tag[k+1])
      );
   end

   // ---------------- duty arithmetic ----------------
   logic signed [U_W-1:0] rot_u;
   logic [SECTOR_BITS-1:0] rot_sector;

   logic v5_ff;
   logic signed [PW-1:0] pc5_ff;
   logic signed [RW-1:0] s5_ff;
   logic signed [U_W-1:0] u5_ff;
   logic [SECTOR_BITS-1:0] sector5_ff;

   assign {rot_u, rot_sector} = rot_tag[CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         pc5_ff <= PW'(rot_x[CORDIC_STEPS]) * PW'(SIN60_Q30);
         s5_ff <= rot_y[CORDIC_STEPS];
         u5_ff <= rot_u;
         sector5_ff <= rot_sector;
      end
   end

   // sin(60deg - phi) = sin60 * cos(phi) - sin(phi) / 2, in Q30.
   logic signed [PW-1:0] s60_full;
   logic signed [RW-1:0] s60;

   logic v6_ff;
   logic signed [MW-1:0] m1_6_ff;
   logic signed [MW-1:0] m2_6_ff;
   logic [SECTOR_BITS-1:0] sector6_ff;

   assign s60_full = (pc5_ff - (PW'(s5_ff) <<< 29)) >>> 30;
   assign s60 = RW'(s60_full);

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_6_ff <= MW'(s60) * MW'(u5_ff);
         m2_6_ff <= MW'(s5_ff) * MW'(u5_ff);
         sector6_ff <= sector5_ff;
      end
   end

   logic signed [MW-1:0] m1_shift;
   logic signed [MW-1:0] m2_shift;

   logic v7_ff;
   logic signed [KW-1:0] k1_7_ff;
   logic signed [KW-1:0] k2_7_ff;
   logic [SECTOR_BITS-1:0] sector7_ff;

   assign m1_shift = m1_6_ff >>> 15;
   assign m2_shift = m2_6_ff >>> 15;

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_7_ff <= KW'($signed(m1_shift[31:0])) * KW'(SQRT3_Q30);
         k2_7_ff <= KW'($signed(m2_shift[31:0])) * KW'(SQRT3_Q30);
         sector7_ff <= sector6_ff;
      end
   end

   function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [TW-1:0] v);
      logic [DUTY_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > TW'(ONE_Q30)) begin
         r = DUTY_W'(ONE_Q30);
      end else begin
         r = DUTY_W'(v);
      end
      return r;
   endfunction

   logic signed [KW-1:0] k1_shift;
   logic signed [KW-1:0] k2_shift;
   logic signed [TW-1:0] t1;
   logic signed [TW-1:0] t2;
   logic signed [TW-1:0] t0;
   logic signed [TW-1:0] h;
   logic signed [TW-1:0] ta;
   logic signed [TW-1:0] tb;
   logic signed [TW-1:0] tc;

   logic v8_ff;
   logic [DUTY_W-1:0] duty_a8_ff;
   logic [DUTY_W-1:0] duty_b8_ff;
   logic [DUTY_W-1:0] duty_c8_ff;
   logic [SECTOR_BITS-1:0] sector8_ff;

   assign k1_shift = k1_7_ff >>> 30;
   assign k2_shift = k2_7_ff >>> 30;
   assign t1 = TW'(k1_shift);
   assign t2 = TW'(k2_shift);
   assign t0 = TW'(ONE_Q30) - t1 - t2;
   assign h = t0 >>> 1;

   always_comb begin
      case (sector7_ff)
         3'd0: begin
            ta = t1 + t2 + h;
            tb = t2 + h;
            tc = h;
         end
         3'd1: begin
            ta = t1 + h;
            tb = t1 + t2 + h;
            tc = h;
         end
         3'd2: begin
            ta = h;
            tb = t1 + t2 + h;
            tc = t2 + h;
         end
         3'd3: begin
            ta = h;
            tb = t1 + h;
            tc = t1 + t2 + h;
         end
         3'd4: begin
            ta = t2 + h;
            tb = h;
            tc = t1 + t2 + h;
         end
         default: begin
            ta = t1 + t2 + h;
            tb = h;
            tc = t1 + h;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         duty_a8_ff <= clamp_duty(ta);
         duty_b8_ff <= clamp_duty(tb);
         duty_c8_ff <= clamp_duty(tc);
         sector8_ff <= sector7_ff;
      end
   end

   // ---------------- compare scaling and output register ----------------
   logic [CPW-1:0] cmp_a;
   logic [CPW-1:0] cmp_b;
   logic [CPW-1:0] cmp_c;

   logic v9_ff;
   rsp_payload_type rsp9_ff;

   assign cmp_a = CPW'(duty_a8_ff) * CPW'(period_ff);
   assign cmp_b = CPW'(duty_b8_ff) * CPW'(period_ff);
   assign cmp_c = CPW'(duty_c8_ff) * CPW'(period_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp9_ff.compare_a <= cmp_a[30+COMPARE_BITS-1:30];
         rsp9_ff.compare_b <= cmp_b[30+COMPARE_BITS-1:30];
         rsp9_ff.compare_c <= cmp_c[30+COMPARE_BITS-1:30];
         rsp9_ff.sector_number <= sector8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= rot_valid[CORDIC_STEPS];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   assign rsp_valid = v9_ff;
   assign rsp_payload = rsp9_ff;

   // ---------------- assertions ----------------
   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while the result beat is stalled");

   a_ratio_clamped : assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (u3_ff <= RATIO_CLAMP) && (u3_ff >= -RATIO_CLAMP))
      else $error("modulation ratio outside the clamp");

   a_duty_range : assert property (@(posedge clock) disable iff (reset)
      v8_ff |-> (duty_a8_ff <= DUTY_W'(ONE_Q30)) && (duty_b8_ff <= DUTY_W'(ONE_Q30))
         && (duty_c8_ff <= DUTY_W'(ONE_Q30)))
      else $error("duty above one");

   a_zero_period : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (period_ff == '0) |-> (rsp_payload.compare_a == '0)
         && (rsp_payload.compare_b == '0) && (rsp_payload.compare_c == '0))
      else $error("nonzero compare with a zero period");

endmodule

[src/svpd_cordic_cell.sv]
module svpd_cordic_cell
   import svpd_pkg::*;
#(
   parameter int XW = 33,
   parameter int ZW = 26,
   parameter int STEP = 0,
   parameter int TAG_W = 8,
   parameter bit VECTORING = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic [ZW-1:0]        in_z,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic [ZW-1:0]        out_z,
   output logic [TAG_W-1:0]     out_tag
);

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;
   logic [ZW-1:0] angle_step;
   logic clockwise;
   logic valid_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic [ZW-1:0] z_ff, z_in;
   logic [TAG_W-1:0] tag_ff;

   assign dx = in_y >>> STEP;
   assign dy = in_x >>> STEP;
   assign angle_step = ZW'(atan_turn(STEP));

   // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
   assign clockwise = VECTORING ? (in_y > 0) : in_z[ZW-1];

   assign x_in = clockwise ? in_x + dx : in_x - dx;
   assign y_in = clockwise ? in_y - dy : in_y + dy;
   assign z_in = clockwise ? in_z + angle_step : in_z - angle_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
   assign out_tag = tag_ff;

endmodule

[src/svpd_root_cell.sv]
module svpd_root_cell #(
   parameter int W = 32,
   parameter int STEP = 0,
   parameter int STEPS = 16,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [W-1:0]     in_rem,
   input  logic [W-1:0]     in_root,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [W-1:0]     out_rem,
   output logic [W-1:0]     out_root,
   output logic [TAG_W-1:0] out_tag
);

   // Each cell settles one result bit, testing one power of four.
   localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - STEP));

   logic [W:0] trial;
   logic fits;
   logic valid_ff;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] root_ff, root_in;
   logic [TAG_W-1:0] tag_ff;

   assign trial = {1'b0, in_root} + {1'b0, BIT};
   assign fits = {1'b0, in_rem} >= trial;
   assign rem_in = fits ? in_rem - trial[W-1:0] : in_rem;
   assign root_in = fits ? (in_root >> 1) + BIT : in_root >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem = rem_ff;
   assign out_root = root_ff;
   assign out_tag = tag_ff;

endmodule

[src/svpd_div_cell.sv]
module svpd_div_cell #(
   parameter int DW = 15,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [DW-1:0]    divisor,
   input  logic             in_valid,
   input  logic [DW-1:0]    in_rem,
   input  logic [DW-1:0]    in_quo,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [DW-1:0]    out_rem,
   output logic [DW-1:0]    out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic [DW:0] shifted;
   logic [DW:0] diff;
   logic fits;
   logic valid_ff;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [TAG_W-1:0] tag_ff;

   // While the incoming remainder is below the divisor, the new one stays below it and fits in DW bits.
   assign shifted = {in_rem, 1'b0};
   assign diff = shifted - {1'b0, divisor};
   assign fits = shifted >= {1'b0, divisor};
   assign rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
   assign quo_in = {in_quo[DW-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem = rem_ff;
   assign out_quo = quo_ff;
   assign out_tag = tag_ff;

endmodule
